FILE: hdl/ksort_pkg.sv
// Package for the key/index insertion sorter: shared constants, operation and
// status codes, and the control struct that the top level broadcasts to the cells.
// No dependencies.
package ksort_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS     = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RETURNED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: hdl/ksort_cell.sv
// One cell of the sorting chain: holds a key, a tag and a valid bit.
// Depends on ksort_pkg for the control struct and the tag width.
module ksort_cell #(
    parameter int KEY_BITS = ksort_pkg::KEY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ksort_pkg::cell_ctrl_t             ctrl,
    input  logic signed [KEY_BITS-1:0]        new_key,
    input  logic [ksort_pkg::TAG_BITS-1:0]    new_tag,
    input  logic signed [KEY_BITS-1:0]        left_key,
    input  logic [ksort_pkg::TAG_BITS-1:0]    left_tag,
    input  logic                              left_valid,
    input  logic                              left_greater,
    input  logic signed [KEY_BITS-1:0]        right_key,
    input  logic [ksort_pkg::TAG_BITS-1:0]    right_tag,
    input  logic                              right_valid,
    output logic signed [KEY_BITS-1:0]        cell_key,
    output logic [ksort_pkg::TAG_BITS-1:0]    cell_tag,
    output logic                              cell_valid,
    output logic                              greater
);
    import ksort_pkg::*;

    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0]        tag_reg;
    logic [TAG_BITS-1:0]        tag_next;
    logic                       valid_reg;
    logic                       valid_next;

    // A stored key strictly greater than the new one moves right, so equal
    // keys keep their arrival order.
    assign greater = valid_reg && (key_reg > new_key);

    always_comb
    begin
        key_next   = key_reg;
        tag_next   = tag_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            if (left_greater)
            begin
                key_next   = left_key;
                tag_next   = left_tag;
                valid_next = 1'b1;
            end
            else if ((greater || !valid_reg) && left_valid)
            begin
                key_next   = new_key;
                tag_next   = new_tag;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop)
        begin
            key_next   = right_key;
            tag_next   = right_tag;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign cell_key   = key_reg;
    assign cell_tag   = tag_reg;
    assign cell_valid = valid_reg;

endmodule

FILE: hdl/key_index_sorter_top.sv
// Top level of the key/index insertion sorter: the cell chain and the output register.
// Depends on ksort_pkg and ksort_cell.
//
// The sorter keeps up to CAPACITY (key, tag) entries in ascending signed key order,
// with equal keys leaving first in, first out. It takes one insert or pop per clock
// cycle: every cell compares its key with the incoming key in parallel and the chain
// shifts by one place at the same edge, so an item's result appears in the output
// register on the next cycle. The only thing that holds input back is a result in the
// output register that the receiver has not yet taken; a new item is taken in the same
// cycle as that result's transfer. Inserts into a full store and pops from an empty
// store change nothing and report their own status.
module key_index_sorter_top #(
    parameter int CAPACITY = ksort_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ksort_pkg::KEY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic signed [KEY_BITS-1:0]        key,
    input  logic [ksort_pkg::TAG_BITS-1:0]    tag,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [KEY_BITS-1:0]        out_key,
    output logic [ksort_pkg::TAG_BITS-1:0]    out_tag,
    output logic                              now_empty
);
    import ksort_pkg::*;

    logic signed [KEY_BITS-1:0] chain_key [CAPACITY];
    logic [TAG_BITS-1:0]        chain_tag [CAPACITY];
    logic [CAPACITY-1:0]        chain_valid;
    logic [CAPACITY-1:0]        chain_greater;

    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;
    logic signed [KEY_BITS-1:0] out_key_reg;
    logic signed [KEY_BITS-1:0] out_key_next;
    logic [TAG_BITS-1:0]        out_tag_reg;
    logic [TAG_BITS-1:0]        out_tag_next;
    logic                       now_empty_reg;
    logic                       now_empty_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = chain_valid[CAPACITY-1];
    assign empty    = !chain_valid[0];

    assign ctrl.ins = accept && (op == OP_INSERT) && !full;
    assign ctrl.pop = accept && (op == OP_POP) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [KEY_BITS-1:0] l_key;
            logic [TAG_BITS-1:0]        l_tag;
            logic                       l_valid;
            logic                       l_greater;
            logic signed [KEY_BITS-1:0] r_key;
            logic [TAG_BITS-1:0]        r_tag;
            logic                       r_valid;

            if (gi == 0)
            begin : g_head
                assign l_key     = '0;
                assign l_tag     = '0;
                assign l_valid   = 1'b1;
                assign l_greater = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_key     = chain_key[gi-1];
                assign l_tag     = chain_tag[gi-1];
                assign l_valid   = chain_valid[gi-1];
                assign l_greater = chain_greater[gi-1];
            end

            if (gi == CAPACITY-1)
            begin : g_tail
                assign r_key   = '0;
                assign r_tag   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_key   = chain_key[gi+1];
                assign r_tag   = chain_tag[gi+1];
                assign r_valid = chain_valid[gi+1];
            end

            ksort_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .new_key      (key),
                .new_tag      (tag),
                .left_key     (l_key),
                .left_tag     (l_tag),
                .left_valid   (l_valid),
                .left_greater (l_greater),
                .right_key    (r_key),
                .right_tag    (r_tag),
                .right_valid  (r_valid),
                .cell_key     (chain_key[gi]),
                .cell_tag     (chain_tag[gi]),
                .cell_valid   (chain_valid[gi]),
                .greater      (chain_greater[gi])
            );
        end
    endgenerate

    always_comb
    begin
        out_key_next = '0;
        out_tag_next = '0;
        if (op == OP_INSERT)
        begin
            status_next    = full ? ST_FULL : ST_INSERTED;
            now_empty_next = 1'b0;
        end
        else if (empty)
        begin
            status_next    = ST_EMPTY;
            now_empty_next = 1'b1;
        end
        else
        begin
            status_next    = ST_RETURNED;
            out_key_next   = chain_key[0];
            out_tag_next   = chain_tag[0];
            now_empty_next = !chain_valid[1];
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_key_reg   <= out_key_next;
            out_tag_reg   <= out_tag_next;
            now_empty_reg <= now_empty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign now_empty = now_empty_reg;

    // Valid cells always form an unbroken run starting at the head of the chain.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid & ~{chain_valid[CAPACITY-2:0], 1'b1}) == '0)
        else $error("valid cells are not contiguous from the head");

    // A pop on a non-empty store must report the returned entry.
    a_pop_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (out_valid && status == ST_RETURNED
                      && out_key == $past(chain_key[0])))
        else $error("pop did not return the head entry");

    // An accepted insert always leaves the head cell occupied.
    a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_INSERT) |=> (chain_valid[0] && !now_empty))
        else $error("insert left the store empty");

endmodule
